[rtl/core/dlps_pkg.sv]
// Shared types and constants for the display-list pixel shader.
package dlps_pkg;

    localparam int MAX_COMMANDS_DEF = 16;
    // wide enough for a fill count of up to 64 entries
    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_SHADE  = 2'd1,
        CMD_END    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NOP   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_RECT  = 2'd2,
        KIND_GRAD  = 2'd3
    } kind_t;

    // request travelling down the command chain
    typedef struct packed {
        logic             vld;
        cmd_t             cmd;
        kind_t            kind;
        logic [15:0]      rect_x;
        logic [15:0]      rect_y;
        logic [15:0]      rect_w;
        logic [15:0]      rect_h;
        logic [31:0]      fill_color;
        logic [7:0]       off_x;
        logic [7:0]       off_y;
        logic [15:0]      pix_x;
        logic [15:0]      pix_y;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        logic [31:0]      pcolor;
        logic             written;
        logic             status;
    } tok_t;

endpackage

[rtl/core/dlps_cell.sv]
// One display-list slot: stores a command and applies it to passing shade requests.
module dlps_cell
    import dlps_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [31:0] clear_color,
    input  tok_t        tok_in,
    output tok_t        tok_out
);

    localparam logic [CNT_W-1:0] SLOT = CNT_W'(IDX);

    kind_t       kind_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic [15:0] w_reg;
    logic [15:0] h_reg;
    logic [31:0] color_reg;
    logic [7:0]  ox_reg;
    logic [7:0]  oy_reg;
    tok_t        tok_reg;
    tok_t        tok_next;

    logic [16:0] x_end;
    logic [16:0] y_end;
    logic        hit;
    logic        wr_slot;
    logic        use_slot;
    logic [7:0]  grad_b;
    logic [7:0]  grad_g;

    assign wr_slot  = tok_in.vld && (tok_in.cmd == CMD_APPEND) && (tok_in.idx == SLOT);
    assign use_slot = tok_in.vld && (tok_in.cmd == CMD_SHADE) && (tok_in.cnt > SLOT);

    assign x_end  = {1'b0, x_reg} + {1'b0, w_reg};
    assign y_end  = {1'b0, y_reg} + {1'b0, h_reg};
    assign hit    = (tok_in.pix_x >= x_reg) && ({1'b0, tok_in.pix_x} < x_end) &&
                    (tok_in.pix_y >= y_reg) && ({1'b0, tok_in.pix_y} < y_end);
    assign grad_b = tok_in.pix_x[7:0] + ox_reg;
    assign grad_g = tok_in.pix_y[7:0] + oy_reg;

    always_comb
    begin
        tok_next = tok_in;
        if (use_slot)
        begin
            case (kind_reg)
                KIND_CLEAR:
                begin
                    tok_next.pcolor  = color_reg;
                    tok_next.written = 1'b1;
                end
                KIND_RECT:
                begin
                    if (hit)
                    begin
                        tok_next.pcolor  = color_reg;
                        tok_next.written = 1'b1;
                    end
                end
                KIND_GRAD:
                begin
                    tok_next.pcolor  = {16'd0, grad_g, grad_b};
                    tok_next.written = 1'b1;
                end
                default:
                begin
                    tok_next.pcolor  = clear_color;
                    tok_next.written = 1'b1;
                end
            endcase
        end
    end

    // slot contents: no reset, read only below the fill count
    always_ff @(posedge clk)
    begin
        if (en && wr_slot)
        begin
            kind_reg  <= tok_in.kind;
            x_reg     <= tok_in.rect_x;
            y_reg     <= tok_in.rect_y;
            w_reg     <= tok_in.rect_w;
            h_reg     <= tok_in.rect_h;
            color_reg <= tok_in.fill_color;
            ox_reg    <= tok_in.off_x;
            oy_reg    <= tok_in.off_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/core/display_list_pixel_shader_top.sv]
// Top level of the display-list pixel shader: list head, cell chain and output.
//
//  channel | signals                          | moves
//  input   | in_valid / in_ready, cmd..pix_y  | one request: append, shade or end frame
//  output  | out_valid / out_ready, results   | one result per request
//  config  | cfg_we, cfg_wdata                | clear colour, written at once
//
// A request passes one cell per cycle while the chain is not stalled; each cell registers it.
// One request is taken every cycle while the output is taken or empty.
// A stalled output holds the whole chain; in_ready drops with it.
// Reset empties the list and the chain; slot contents stay as they were.
module display_list_pixel_shader_top
    import dlps_pkg::*;
#(
    parameter int MAX_COMMANDS = MAX_COMMANDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [1:0]  kind,
    input  logic [15:0] rect_x,
    input  logic [15:0] rect_y,
    input  logic [15:0] rect_w,
    input  logic [15:0] rect_h,
    input  logic [31:0] fill_color,
    input  logic [7:0]  grad_off_x,
    input  logic [7:0]  grad_off_y,
    input  logic [15:0] pix_x,
    input  logic [15:0] pix_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_color,
    output logic        written,
    output logic        status,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_COMMANDS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_COMMANDS);

    logic [31:0]   clear_color_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          en;
    logic          accept;
    logic          full;
    cmd_t          cmd_in;
    tok_t          head;
    tok_t          chain [MAX_COMMANDS+1];
    tok_t          tail;

    assign cmd_in = cmd_t'(cmd);
    assign tail   = chain[MAX_COMMANDS];
    assign en     = !tail.vld || out_ready;
    assign in_ready = en;
    assign accept = in_valid && in_ready;
    assign full   = (count_reg == FULL);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            case (cmd_in)
                CMD_APPEND: if (!full) count_next = count_reg + 1'b1;
                CMD_END:    count_next = '0;
                default:    count_next = count_reg;
            endcase
        end
    end

    always_comb
    begin
        head            = '0;
        head.vld        = accept;
        head.cmd        = cmd_in;
        head.kind       = kind_t'(kind);
        head.rect_x     = rect_x;
        head.rect_y     = rect_y;
        head.rect_w     = rect_w;
        head.rect_h     = rect_h;
        head.fill_color = fill_color;
        head.off_x      = grad_off_x;
        head.off_y      = grad_off_y;
        head.pix_x      = pix_x;
        head.pix_y      = pix_y;
        head.cnt        = CNT_W'(count_reg);
        if ((cmd_in == CMD_APPEND) && full)
        begin
            // dropped: no slot matches this index
            head.idx    = {CNT_W{1'b1}};
            head.status = 1'b1;
        end
        else
        begin
            head.idx    = CNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            clear_color_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                clear_color_reg <= cfg_wdata;
            end
        end
    end

    assign chain[0] = head;

    for (genvar i = 0; i < MAX_COMMANDS; i++)
    begin : g_cell
        dlps_cell #(
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .clear_color (clear_color_reg),
            .tok_in      (chain[i]),
            .tok_out     (chain[i+1])
        );
    end

    assign out_valid   = tail.vld;
    assign pixel_color = tail.pcolor;
    assign written     = tail.written;
    assign status      = tail.status;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("list count beyond capacity");

    a_end_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd_in == CMD_END) |=> count_reg == '0)
        else $error("end of frame left entries");

    a_drop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !written && (pixel_color == 32'd0))
        else $error("dropped append produced a pixel");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !written |-> pixel_color == 32'd0)
        else $error("unwritten pixel not zero");

endmodule

[sim/display_list_pixel_shader_top_tb.sv]
// Self-checking testbench for the display-list pixel shader top level.
`timescale 1ns / 100ps

module display_list_pixel_shader_top_tb;
    import dlps_pkg::*;

    localparam int MAX_CMDS    = MAX_COMMANDS_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int PRINT_CAP   = 150;

    typedef struct packed {
        cmd_t        cmd;
        kind_t       kind;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] rw;
        logic [15:0] rh;
        logic [31:0] fill;
        logic [7:0]  ox;
        logic [7:0]  oy;
        logic [15:0] px;
        logic [15:0] py;
    } dl_req_t;

    typedef struct packed {
        logic [31:0] color;
        logic        written;
        logic        status;
    } pixel_res_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd        = '0;
    logic [1:0]  kind       = '0;
    logic [15:0] rect_x     = '0;
    logic [15:0] rect_y     = '0;
    logic [15:0] rect_w     = '0;
    logic [15:0] rect_h     = '0;
    logic [31:0] fill_color = '0;
    logic [7:0]  grad_off_x = '0;
    logic [7:0]  grad_off_y = '0;
    logic [15:0] pix_x      = '0;
    logic [15:0] pix_y      = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] pixel_color;
    logic        written;
    logic        status;
    logic        cfg_we     = 1'b0;
    logic [31:0] cfg_wdata  = '0;

    // request backlog and outstanding pixel results
    dl_req_t    req_backlog[$];
    pixel_res_t pixel_expect_q[$];
    dl_req_t    drv_req;
    dl_req_t    seen_req;
    pixel_res_t want;
    logic       steady = 1'b0;
    int         mismatches = 0;
    int         idle_cycles = 0;

    // shadow display list
    logic [31:0] shadow_clear = '0;
    kind_t       lst_kind[MAX_CMDS];
    logic [15:0] lst_x[MAX_CMDS];
    logic [15:0] lst_y[MAX_CMDS];
    logic [15:0] lst_w[MAX_CMDS];
    logic [15:0] lst_h[MAX_CMDS];
    logic [31:0] lst_color[MAX_CMDS];
    logic [7:0]  lst_ox[MAX_CMDS];
    logic [7:0]  lst_oy[MAX_CMDS];
    int          lst_fill = 0;

    // rectangles queued by the generator, for aiming pixels at edges
    logic [15:0] aim_x[MAX_CMDS];
    logic [15:0] aim_y[MAX_CMDS];
    logic [15:0] aim_w[MAX_CMDS];
    logic [15:0] aim_h[MAX_CMDS];
    int          aim_n = 0;
    int          gen_items = 0;

    display_list_pixel_shader_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .kind        (kind),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .fill_color  (fill_color),
        .grad_off_x  (grad_off_x),
        .grad_off_y  (grad_off_y),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color),
        .written     (written),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic pixel_res_t apply_request(dl_req_t r);
        pixel_res_t  res;
        int          i;
        int unsigned px;
        int unsigned py;
        logic [7:0]  b;
        logic [7:0]  g;
        res = '0;
        px  = 32'(r.px);
        py  = 32'(r.py);
        case (r.cmd)
            CMD_APPEND:
            begin
                if (lst_fill >= MAX_CMDS)
                    res.status = 1'b1;
                else
                begin
                    lst_kind[lst_fill]  = r.kind;
                    lst_x[lst_fill]     = r.rx;
                    lst_y[lst_fill]     = r.ry;
                    lst_w[lst_fill]     = r.rw;
                    lst_h[lst_fill]     = r.rh;
                    lst_color[lst_fill] = r.fill;
                    lst_ox[lst_fill]    = r.ox;
                    lst_oy[lst_fill]    = r.oy;
                    lst_fill++;
                end
            end
            CMD_SHADE:
            begin
                for (i = 0; i < lst_fill; i++)
                begin
                    case (lst_kind[i])
                        KIND_CLEAR:
                        begin
                            res.color   = lst_color[i];
                            res.written = 1'b1;
                        end
                        KIND_RECT:
                        begin
                            // bounds compared unwrapped
                            if (px >= lst_x[i] && px < int'(lst_x[i]) + int'(lst_w[i]) &&
                                py >= lst_y[i] && py < int'(lst_y[i]) + int'(lst_h[i]))
                            begin
                                res.color   = lst_color[i];
                                res.written = 1'b1;
                            end
                        end
                        KIND_GRAD:
                        begin
                            b           = r.px[7:0] + lst_ox[i];
                            g           = r.py[7:0] + lst_oy[i];
                            res.color   = {16'h0000, g, b};
                            res.written = 1'b1;
                        end
                        default:
                        begin
                            res.color   = shadow_clear;
                            res.written = 1'b1;
                        end
                    endcase
                end
            end
            CMD_END:
                lst_fill = 0;
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s mismatch, got %h want %h", $time, what, got, exp_val);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= 18))
            begin
                drv_req = req_backlog.pop_front();
                cmd        <= drv_req.cmd;
                kind       <= drv_req.kind;
                rect_x     <= drv_req.rx;
                rect_y     <= drv_req.ry;
                rect_w     <= drv_req.rw;
                rect_h     <= drv_req.rh;
                fill_color <= drv_req.fill;
                grad_off_x <= drv_req.ox;
                grad_off_y <= drv_req.oy;
                pix_x      <= drv_req.px;
                pix_y      <= drv_req.py;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result sink
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(99) >= 18);
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pixel_expect_q.size() == 0)
                    note_mismatch("unexpected result", pixel_color, '0);
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (pixel_color !== want.color)
                        note_mismatch("pixel_color", pixel_color, want.color);
                    if (written !== want.written)
                        note_mismatch("written", 32'(written), 32'(want.written));
                    if (status !== want.status)
                        note_mismatch("status", 32'(status), 32'(want.status));
                end
            end
            if (in_valid && in_ready)
            begin
                seen_req = {cmd, kind, rect_x, rect_y, rect_w, rect_h, fill_color,
                            grad_off_x, grad_off_y, pix_x, pix_y};
                pixel_expect_q.push_back(apply_request(seen_req));
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic dl_req_t noise_req();
        dl_req_t r;
        r.cmd  = cmd_t'($urandom_range(3));
        r.kind = kind_t'($urandom_range(3));
        r.rx   = 16'($urandom);
        r.ry   = 16'($urandom);
        r.rw   = 16'($urandom);
        r.rh   = 16'($urandom);
        r.fill = $urandom;
        r.ox   = 8'($urandom);
        r.oy   = 8'($urandom);
        r.px   = 16'($urandom);
        r.py   = 16'($urandom);
        return r;
    endfunction

    task automatic push_req(input dl_req_t r);
        req_backlog.push_back(r);
        gen_items++;
    endtask

    task automatic push_plain(input cmd_t c);
        dl_req_t r;
        r     = noise_req();
        r.cmd = c;
        if (c == CMD_END)
            aim_n = 0;
        push_req(r);
    endtask

    task automatic push_append(input kind_t k, input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] w, input logic [15:0] h,
                               input logic [31:0] c, input logic [7:0] ox,
                               input logic [7:0] oy);
        dl_req_t r;
        r      = noise_req();
        r.cmd  = CMD_APPEND;
        r.kind = k;
        r.rx   = x;
        r.ry   = y;
        r.rw   = w;
        r.rh   = h;
        r.fill = c;
        r.ox   = ox;
        r.oy   = oy;
        if (aim_n < MAX_CMDS)
        begin
            aim_x[aim_n] = x;
            aim_y[aim_n] = y;
            aim_w[aim_n] = w;
            aim_h[aim_n] = h;
            aim_n++;
        end
        push_req(r);
    endtask

    task automatic push_shade(input logic [15:0] px, input logic [15:0] py);
        dl_req_t r;
        r     = noise_req();
        r.cmd = CMD_SHADE;
        r.px  = px;
        r.py  = py;
        push_req(r);
    endtask

    function automatic logic [15:0] pick_edge();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4, 5, 6:
                     return 16'($urandom_range(300));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_span();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4, 5, 6:
                     return 16'($urandom_range(1, 200));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] aim_near(input logic [15:0] lo, input logic [15:0] span);
        case ($urandom_range(4))
            0:       return lo - 16'd1;
            1:       return lo;
            2:       return lo + span - 16'd1;
            3:       return lo + span;
            default: return lo + 16'($urandom_range(span));
        endcase
    endfunction

    task automatic push_random_append();
        kind_t k;
        k = ($urandom_range(2) == 0) ? kind_t'($urandom_range(3)) : KIND_RECT;
        push_append(k, pick_edge(), pick_edge(), pick_span(), pick_span(), $urandom,
                    8'($urandom), 8'($urandom));
    endtask

    task automatic push_random_shade();
        int i;
        int roll;
        roll = $urandom_range(9);
        if (aim_n > 0 && roll < 6)
        begin
            i = $urandom_range(aim_n - 1);
            push_shade(aim_near(aim_x[i], aim_w[i]), aim_near(aim_y[i], aim_h[i]));
        end
        else if (roll < 8)
            push_shade(16'($urandom_range(400)), 16'($urandom_range(400)));
        else
            push_shade(16'($urandom), 16'($urandom));
    endtask

    task automatic push_random_frame();
        int n_app;
        int n_sh;
        n_app = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 7);
        n_sh  = $urandom_range(1, 8);
        while (n_app + n_sh > 0)
        begin
            if ($urandom_range(19) == 0)
                push_req(noise_req());
            if ($urandom_range(n_app + n_sh - 1) < n_app)
            begin
                push_random_append();
                n_app--;
            end
            else
            begin
                push_random_shade();
                n_sh--;
            end
        end
        if ($urandom_range(9) != 0)
            push_plain(CMD_END);
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || in_valid || pixel_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_clear_color(input logic [31:0] v);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_clear = v;
    endtask

    initial
    begin
        int ph;
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frame
        set_clear_color(32'hA5C3_1E7F);
        push_shade(16'($urandom), 16'($urandom));
        push_plain(CMD_NONE);
        push_append(KIND_NOP, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0, 8'h00, 8'h00);
        push_shade(16'd7, 16'd9);
        push_append(KIND_RECT, 16'd10, 16'd20, 16'd5, 16'd3, 32'h1122_3344, 8'h00, 8'h00);
        push_shade(16'd10, 16'd20);
        push_shade(16'd14, 16'd22);
        push_shade(16'd15, 16'd22);
        push_shade(16'd14, 16'd23);
        push_append(KIND_RECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                    8'hFF, 8'hFF);
        push_shade(16'hFFFF, 16'hFFFF);
        push_append(KIND_RECT, 16'd0, 16'd0, 16'd0, 16'hFFFF, 32'hDEAD_BEEF, 8'h00, 8'h00);
        push_shade(16'd0, 16'd0);
        push_append(KIND_GRAD, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    $urandom, 8'hFF, 8'hFF);
        push_shade(16'hFFFF, 16'd1);
        push_append(KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    32'h8000_0001, 8'h00, 8'h00);
        for (k = 0; k < MAX_CMDS - 6; k++)
            push_random_append();
        push_random_append();
        push_shade(16'($urandom), 16'($urandom));
        push_plain(CMD_END);
        push_shade(16'($urandom), 16'($urandom));

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       set_clear_color(32'h0000_0000);
                1:       set_clear_color(32'hFFFF_FFFF);
                default: set_clear_color($urandom);
            endcase
            steady    = (ph == 3);
            gen_items = 0;
            while (gen_items < 200)
                push_random_frame();
        end
        wait_drained();
        steady = 1'b0;
        repeat (MAX_CMDS + 8) @(negedge clk);

        if (pixel_expect_q.size() != 0)
            note_mismatch("results outstanding", pixel_expect_q.size(), '0);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
